// File: sv/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// No dependencies; imported by button_press_classifier_core and its testbench.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned MsW     = 16;
    localparam int unsigned IdW     = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned SDataW  = 40;
    localparam int unsigned MDataW  = 16;

    localparam logic [MsW-1:0]   DebounceRst = 16'd20;
    localparam logic [MsW-1:0]   DoubleRst   = 16'd250;
    localparam logic [MsW-1:0]   HoldRst     = 16'd750;
    localparam logic [TimeW-1:0] TimeRst     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } event_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_DOUBLE_WIN = 3'd1,
        REG_HOLD       = 3'd2,
        REG_IDLE_LEVEL = 3'd3,
        REG_BUTTON_ID  = 3'd4
    } cfg_reg_t;

    // signed (a - b) > k for non-negative k
    function automatic logic diff_gt(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b,
                                     input logic [MsW-1:0] k);
        logic [TimeW-1:0] d;
        d = a - b;
        return !d[TimeW-1] && (d > {{(TimeW-MsW){1'b0}}, k});
    endfunction

    // signed (a - b) >= k for non-negative k
    function automatic logic diff_ge(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b,
                                     input logic [MsW-1:0] k);
        logic [TimeW-1:0] d;
        d = a - b;
        return !d[TimeW-1] && (d >= {{(TimeW-MsW){1'b0}}, k});
    endfunction

endpackage

// File: sv/button_press_classifier_core.sv
// Path: an accepted sample request is loaded into the input register; its classified event moves
// into the output register when that is free. Throughput: one sample per cycle unless m_tready
// stalls the output stage; the press/release state is updated in the same cycle a sample moves
// to the output register. Reset (aresetn low, synchronous): registers return to 20/250/750/0/0,
// the button state to released-history defaults, both stream stages empty.
// Top level of the button press classifier; depends on bpc_pkg.
`timescale 1ns / 1ps

module button_press_classifier_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bpc_pkg::MsW-1:0]       cfg_data,
    // sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpc_pkg::SDataW-1:0]    s_tdata,   // [0] level, [32:1] now_ms, rest zero
    // event stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpc_pkg::MDataW-1:0]    m_tdata    // [1:0] event_res, [9:2] event_button
);
    import bpc_pkg::*;

    // configuration
    logic [MsW-1:0] debounce_reg;
    logic [MsW-1:0] double_win_reg;
    logic [MsW-1:0] hold_reg;
    logic           idle_level_reg;
    logic [IdW-1:0] button_id_reg;

    // input stage
    logic             in_valid_reg;
    logic             in_level_reg;
    logic [TimeW-1:0] in_now_reg;

    // output stage
    logic             out_valid_reg;
    event_t           out_event_reg;
    logic [IdW-1:0]   out_button_reg;

    // button state
    logic             last_level_reg,     last_level_next;
    logic [TimeW-1:0] press_time_reg,     press_time_next;
    logic [TimeW-1:0] release_time_reg,   release_time_next;
    logic             dbl_waiting_reg,    dbl_waiting_next;
    logic             dbl_on_release_reg, dbl_on_release_next;
    logic             single_ok_reg,      single_ok_next;
    logic             ignore_rel_reg,     ignore_rel_next;
    logic             hold_seen_reg,      hold_seen_next;
    event_t           event_next;

    logic out_free;
    logic advance;
    logic pressed;
    logic was_pressed;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(MDataW-IdW-2){1'b0}}, out_button_reg, out_event_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DebounceRst;
            double_win_reg <= DoubleRst;
            hold_reg       <= HoldRst;
            idle_level_reg <= 1'b0;
            button_id_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_DOUBLE_WIN: double_win_reg <= cfg_data;
                REG_HOLD:       hold_reg       <= cfg_data;
                REG_IDLE_LEVEL: idle_level_reg <= cfg_data[0];
                REG_BUTTON_ID:  button_id_reg  <= cfg_data[IdW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[TimeW:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg  <= event_next;
            out_button_reg <= button_id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg     <= 1'b1;
            press_time_reg     <= TimeRst;
            release_time_reg   <= TimeRst;
            dbl_waiting_reg    <= 1'b0;
            dbl_on_release_reg <= 1'b0;
            single_ok_reg      <= 1'b0;
            ignore_rel_reg     <= 1'b0;
            hold_seen_reg      <= 1'b0;
        end else if (advance) begin
            last_level_reg     <= last_level_next;
            press_time_reg     <= press_time_next;
            release_time_reg   <= release_time_next;
            dbl_waiting_reg    <= dbl_waiting_next;
            dbl_on_release_reg <= dbl_on_release_next;
            single_ok_reg      <= single_ok_next;
            ignore_rel_reg     <= ignore_rel_next;
            hold_seen_reg      <= hold_seen_next;
        end
    end

    assign pressed     = (in_level_reg != idle_level_reg);
    assign was_pressed = (last_level_reg != idle_level_reg);

    always_comb begin
        press_time_next     = press_time_reg;
        release_time_next   = release_time_reg;
        dbl_waiting_next    = dbl_waiting_reg;
        dbl_on_release_next = dbl_on_release_reg;
        single_ok_next      = single_ok_reg;
        ignore_rel_next     = ignore_rel_reg;
        hold_seen_next      = hold_seen_reg;
        last_level_next     = in_level_reg;
        event_next          = EV_NONE;

        // debounced press or release edge
        if (pressed && !was_pressed
                && diff_gt(in_now_reg, release_time_reg, debounce_reg)) begin
            press_time_next = in_now_reg;
            ignore_rel_next = 1'b0;
            single_ok_next  = 1'b1;
            hold_seen_next  = 1'b0;
            if (!diff_ge(in_now_reg, release_time_reg, double_win_reg)
                    && !dbl_on_release_reg && dbl_waiting_reg) begin
                dbl_on_release_next = 1'b1;
            end else begin
                dbl_on_release_next = 1'b0;
                dbl_waiting_next    = 1'b0;
            end
        end else if (!pressed && was_pressed
                && diff_gt(in_now_reg, press_time_reg, debounce_reg)) begin
            if (!ignore_rel_reg) begin
                release_time_next = in_now_reg;
                if (!dbl_on_release_reg) begin
                    dbl_waiting_next = 1'b1;
                end else begin
                    event_next          = EV_DOUBLE;
                    dbl_on_release_next = 1'b0;
                    dbl_waiting_next    = 1'b0;
                    single_ok_next      = 1'b0;
                end
            end
        end

        // single press once the double window has closed
        if (!pressed && diff_ge(in_now_reg, release_time_next, double_win_reg)
                && dbl_waiting_next && !dbl_on_release_next && single_ok_next
                && event_next != EV_DOUBLE) begin
            event_next       = EV_SINGLE;
            dbl_waiting_next = 1'b0;
        end

        // hold fires and re-arms every hold period
        if (pressed && diff_ge(in_now_reg, press_time_next, hold_reg)) begin
            if (!hold_seen_next) begin
                ignore_rel_next     = 1'b1;
                dbl_on_release_next = 1'b0;
                dbl_waiting_next    = 1'b0;
                hold_seen_next      = 1'b1;
            end
            press_time_next = in_now_reg;
            event_next      = EV_HOLD;
        end
    end

`ifndef SYNTHESIS
    a_dbl_needs_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        dbl_on_release_reg |-> dbl_waiting_reg)
        else $error("double-on-release armed without a waiting press");

    a_hold_marks_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && event_next == EV_HOLD) |=> (hold_seen_reg && ignore_rel_reg))
        else $error("hold event left hold state clear");

    a_empty_out_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_output_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed request did not reach output stage");
`endif

endmodule

// File: bench/button_press_classifier_core_tb.sv
// Self-checking bench for button_press_classifier_core: directed table, then random gestures.
// Depends on bpc_pkg and the core; predicts each event in-bench and checks it field by field.
`timescale 1ns / 1ps

module button_press_classifier_core_tb;
    import bpc_pkg::*;

    localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;   // highest index with no register behind it
    localparam int PhaseSamples = 170;
    localparam int NumPhases    = 6;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               lvl;
        logic [TimeW-1:0]   stamp;
        logic               typed;
        event_t             ev;
        logic [CfgIdxW-1:0] idx;
        logic [MsW-1:0]     val;
    } row_t;

    typedef struct {
        event_t           kind_ev;
        logic [IdW-1:0]   id;
    } press_event_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index = '0;
    logic [MsW-1:0]       cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SDataW-1:0]    s_tdata   = '0;   // [0] level, [32:1] now_ms, rest zero
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [MDataW-1:0]    m_tdata;          // [1:0] event_res, [9:2] event_button

    // Predictor configuration and button history, reset values
    logic [TimeW-1:0] debounce_cfg = TimeW'(DebounceRst);
    logic [TimeW-1:0] window_cfg   = TimeW'(DoubleRst);
    logic [TimeW-1:0] hold_cfg     = TimeW'(HoldRst);
    logic             idle_cfg     = 1'b0;
    logic [IdW-1:0]   id_cfg       = '0;

    logic             prev_level   = 1'b1;
    logic [TimeW-1:0] press_ms     = TimeRst;
    logic [TimeW-1:0] release_ms   = TimeRst;
    logic             dbl_pending  = 1'b0;
    logic             dbl_armed    = 1'b0;
    logic             single_ok    = 1'b0;
    logic             skip_release = 1'b0;
    logic             hold_fired   = 1'b0;

    press_event_t awaited_events[$];
    int  mismatches    = 0;
    int  events_seen   = 0;
    int  samples_sent  = 0;
    int  send_idle_pct = 30;
    int  take_idle_pct = 73;
    int  hold_off_left = 0;
    bit  hold_off_done = 1'b0;
    logic [TimeW-1:0] clock_ms;

    row_t directed_rows [0:26] = '{
        '{ROW_SAMPLE, 1'b0, 32'd0,        1'b1, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd100,      1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'd200,      1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'd449,      1'b1, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'd450,      1'b1, EV_SINGLE, REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd500,      1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'd600,      1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd700,      1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'd800,      1'b1, EV_DOUBLE, REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'd1100,     1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd1110,     1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        // bounce: release exactly on the debounce time does not count
        '{ROW_SAMPLE, 1'b0, 32'd1130,     1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd1140,     1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd1890,     1'b1, EV_HOLD,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd2639,     1'b1, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd2640,     1'b1, EV_HOLD,   REG_DEBOUNCE, 16'd0},
        // release after a hold yields nothing, not even later
        '{ROW_SAMPLE, 1'b0, 32'd2700,     1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'd3200,     1'b1, EV_NONE,   REG_DEBOUNCE, 16'd0},
        // timestamps running backwards
        '{ROW_SAMPLE, 1'b1, 32'd100,      1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b0, 32'hFFFF_FFFF, 1'b0, EV_NONE,  REG_DEBOUNCE, 16'd0},
        // zero hold time
        '{ROW_WRITE,  1'b0, 32'd0,        1'b0, EV_NONE,   REG_HOLD,       16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd5000,     1'b1, EV_HOLD,   REG_DEBOUNCE, 16'd0},
        '{ROW_SAMPLE, 1'b1, 32'd5000,     1'b1, EV_HOLD,   REG_DEBOUNCE, 16'd0},
        // pull-up wiring, a write to a spare index, a new identifier
        '{ROW_WRITE,  1'b0, 32'd0,        1'b0, EV_NONE,   REG_IDLE_LEVEL, 16'd1},
        '{ROW_WRITE,  1'b0, 32'd0,        1'b0, EV_NONE,   RegSpare,       16'hFFFF},
        '{ROW_WRITE,  1'b0, 32'd0,        1'b0, EV_NONE,   REG_BUTTON_ID,  16'hFFFF},
        '{ROW_SAMPLE, 1'b0, 32'd6000,     1'b0, EV_NONE,   REG_DEBOUNCE, 16'd0}
    };

    button_press_classifier_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // signed (now - mark) beyond k, wrapping modulo 2^32
    function automatic logic elapsed_past(input logic [TimeW-1:0] now_t,
                                          input logic [TimeW-1:0] mark,
                                          input logic [TimeW-1:0] k, input logic inclusive);
        logic [TimeW-1:0] d;
        d = now_t - mark;
        return !d[TimeW-1] && (inclusive ? (d >= k) : (d > k));
    endfunction

    function automatic event_t classify_press(input logic lvl, input logic [TimeW-1:0] now_t);
        logic   down;
        logic   was_down;
        event_t ev;
        down     = (lvl != idle_cfg);
        was_down = (prev_level != idle_cfg);
        ev       = EV_NONE;
        if (down && !was_down && elapsed_past(now_t, release_ms, debounce_cfg, 1'b0)) begin
            press_ms     = now_t;
            skip_release = 1'b0;
            single_ok    = 1'b1;
            hold_fired   = 1'b0;
            if (!elapsed_past(now_t, release_ms, window_cfg, 1'b1) && !dbl_armed && dbl_pending) begin
                dbl_armed = 1'b1;
            end else begin
                dbl_armed   = 1'b0;
                dbl_pending = 1'b0;
            end
        end else if (!down && was_down && elapsed_past(now_t, press_ms, debounce_cfg, 1'b0)) begin
            if (!skip_release) begin
                release_ms = now_t;
                if (!dbl_armed) begin
                    dbl_pending = 1'b1;
                end else begin
                    ev          = EV_DOUBLE;
                    dbl_armed   = 1'b0;
                    dbl_pending = 1'b0;
                    single_ok   = 1'b0;
                end
            end
        end
        // single press only once the double window has closed
        if (!down && elapsed_past(now_t, release_ms, window_cfg, 1'b1) && dbl_pending
            && !dbl_armed && single_ok && ev != EV_DOUBLE) begin
            ev          = EV_SINGLE;
            dbl_pending = 1'b0;
        end
        if (down && elapsed_past(now_t, press_ms, hold_cfg, 1'b1)) begin
            if (!hold_fired) begin
                skip_release = 1'b1;
                dbl_armed    = 1'b0;
                dbl_pending  = 1'b0;
                hold_fired   = 1'b1;
            end
            press_ms = now_t;
            ev       = EV_HOLD;
        end
        prev_level = lvl;
        return ev;
    endfunction

    // Leaves cfg_valid high; the next sample request lowers it
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE:   debounce_cfg = TimeW'(val);
            REG_DOUBLE_WIN: window_cfg   = TimeW'(val);
            REG_HOLD:       hold_cfg     = TimeW'(val);
            REG_IDLE_LEVEL: idle_cfg     = val[0];
            REG_BUTTON_ID:  id_cfg       = val[IdW-1:0];
            default: ;
        endcase
    endtask

    task automatic push_sample(input logic lvl, input logic [TimeW-1:0] stamp,
                               input logic typed, input event_t typed_ev);
        event_t ev;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SDataW-TimeW-1){1'b0}}, stamp, lvl};
        do @(posedge aclk); while (!s_tready);
        ev = classify_press(lvl, stamp);
        awaited_events.push_back('{typed ? typed_ev : ev, id_cfg});
        samples_sent++;
    endtask

    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge aclk);
    endtask

    // Gap around a threshold: on it, either side of it, or well clear
    function automatic logic [TimeW-1:0] pick_gap(input logic [TimeW-1:0] k);
        case ($urandom_range(0, 5))
            0: return k;
            1: return k + 1;
            2: return (k == 0) ? k : k - 1;
            3: return $urandom_range(0, k);
            4: return k + $urandom_range(0, k + 8);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic play_gesture();
        logic down_lvl;
        int   n;
        down_lvl = ~idle_cfg;
        case ($urandom_range(0, 9))
            7: begin
                // contact bounce
                n = $urandom_range(2, 5);
                repeat (n) begin
                    clock_ms += $urandom_range(0, debounce_cfg);
                    push_sample(1'($urandom_range(0, 1)), clock_ms, 1'b0, EV_NONE);
                end
            end
            8: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    clock_ms += $urandom_range(0, 3);
                    push_sample(1'($urandom_range(0, 1)), clock_ms, 1'b0, EV_NONE);
                end
            end
            9: begin
                // jump anywhere, backwards included
                clock_ms += $urandom;
                push_sample(1'($urandom_range(0, 1)), clock_ms, 1'b0, EV_NONE);
            end
            default: begin
                clock_ms += pick_gap($urandom_range(0, 1) ? window_cfg : debounce_cfg);
                push_sample(down_lvl, clock_ms, 1'b0, EV_NONE);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    clock_ms += pick_gap(hold_cfg);
                    push_sample(down_lvl, clock_ms, 1'b0, EV_NONE);
                end
                clock_ms += pick_gap(debounce_cfg);
                push_sample(idle_cfg, clock_ms, 1'b0, EV_NONE);
                n = $urandom_range(0, 2);
                repeat (n) begin
                    clock_ms += pick_gap(window_cfg);
                    push_sample(idle_cfg, clock_ms, 1'b0, EV_NONE);
                end
            end
        endcase
    endtask

    initial begin
        int phase_end;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                drain_events();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                push_sample(directed_rows[i].lvl, directed_rows[i].stamp,
                            directed_rows[i].typed, directed_rows[i].ev);
            end
        end

        for (int phase = 0; phase < NumPhases; phase++) begin
            drain_events();
            case (phase)
                0, 1: begin
                    send_idle_pct = 30;
                    take_idle_pct = 73;
                end
                2, 3: begin
                    send_idle_pct = 73;
                    take_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            case (phase)
                1: begin
                    write_reg(REG_DEBOUNCE,   16'd0);
                    write_reg(REG_DOUBLE_WIN, 16'd0);
                    write_reg(REG_HOLD,       16'd0);
                    write_reg(REG_IDLE_LEVEL, 16'd1);
                    write_reg(REG_BUTTON_ID,  16'd255);
                end
                2: begin
                    write_reg(REG_DEBOUNCE,   16'hFFFF);
                    write_reg(REG_DOUBLE_WIN, 16'hFFFF);
                    write_reg(REG_HOLD,       16'hFFFF);
                    write_reg(REG_IDLE_LEVEL, 16'd0);
                    write_reg(REG_BUTTON_ID,  16'd0);
                end
                default: begin
                    write_reg(REG_DEBOUNCE,   MsW'($urandom_range(0, 40)));
                    write_reg(REG_DOUBLE_WIN, MsW'($urandom_range(20, 300)));
                    write_reg(REG_HOLD,       MsW'($urandom_range(50, 800)));
                    write_reg(REG_IDLE_LEVEL, MsW'($urandom_range(0, 16'hFFFF)));
                    write_reg(REG_BUTTON_ID,  MsW'($urandom_range(0, 16'hFFFF)));
                end
            endcase
            write_reg(CfgIdxW'($urandom_range(REG_BUTTON_ID + 1, RegSpare)),
                      MsW'($urandom_range(0, 16'hFFFF)));
            clock_ms  = $urandom;
            phase_end = samples_sent + PhaseSamples;
            while (samples_sent < phase_end) play_gesture();
        end

        drain_events();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Event checker and receiver back-pressure
    always @(posedge aclk) begin
        press_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            events_seen++;
            if (awaited_events.size() == 0) begin
                $error("event_res %0d arrived with no sample request outstanding", m_tdata[1:0]);
                mismatches++;
            end else begin
                want = awaited_events.pop_front();
                if (m_tdata[1:0] !== want.kind_ev) begin
                    $error("event_res: expected %0d, got %0d", want.kind_ev, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[9:2] !== want.id) begin
                    $error("event_button: expected %0d, got %0d", want.id, m_tdata[9:2]);
                    mismatches++;
                end
            end
        end
        // hold off once for a long stretch so the sample side backs up
        if (hold_off_left != 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else if (!hold_off_done && events_seen >= 150) begin
            hold_off_done = 1'b1;
            hold_off_left = 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= take_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
